// ===== hw/rtl/tud_pkg.sv =====
// Shared types, codes and lookup functions of the token unescape decoder.
// Used by tud_front, tud_queue, tud_back and the top level; depends on nothing.
package tud_pkg;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Entity table: five names, held letters at most four
    localparam int ENT_NUM     = 5;
    localparam int ENT_HOLD    = 4;
    localparam int ENT_CNT_W   = 3;

    // Cause codes of a token end
    localparam logic [1:0] CAUSE_TERM  = 2'd0;
    localparam logic [1:0] CAUSE_QUOTE = 2'd1;
    localparam logic [1:0] CAUSE_NUL   = 2'd2;
    localparam logic [1:0] CAUSE_EOI   = 2'd3;

    // Byte codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_BSL   = 8'h5C;

    // What closes a run of results
    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_CHAR,
        KIND_END
    } kind_t;

    // One queued run: optional '&' plus held letters, then an optional final result
    typedef struct packed {
        logic                          amp;
        logic [ENT_CNT_W-1:0]          nlet;
        logic [ENT_HOLD-1:0][7:0]      letters;
        kind_t                         kind;
        logic [1:0]                    cause;
        logic [7:0]                    fin_byte;
        logic                          quoted;
    } desc_t;

    // One result item as registered on the output
    typedef struct packed {
        logic [7:0] char_out;
        logic       char_valid;
        logic       token_end;
        logic [1:0] end_cause;
        logic [7:0] terminator_byte;
        logic       was_quoted;
        logic       last_of_run;
    } result_t;

    // Whitespace skipped before a token (space, 0x09..0x0D)
    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    // Bytes that end an unquoted token
    function automatic logic is_term(input logic [7:0] c);
        return (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0D) ||
               (c == 8'h0B) || (c == 8'h3E) || (c == CH_BSL) || (c == 8'h3D);
    endfunction

    // Backslash escape decode
    function automatic logic [7:0] esc_byte(input logic [7:0] c);
        logic [7:0] r;
        unique case (c)
            8'h61:   r = 8'h07; // a
            8'h62:   r = 8'h08; // b
            8'h66:   r = 8'h0C; // f
            8'h6E:   r = 8'h0A; // n
            8'h72:   r = 8'h0D; // r
            8'h74:   r = 8'h09; // t
            8'h76:   r = 8'h0B; // v
            default: r = c;
        endcase
        return r;
    endfunction

    // Entity names, left aligned, NUL padded
    function automatic logic [39:0] ent_name(input logic [2:0] i);
        logic [39:0] r;
        unique case (i)
            3'd0:    r = "quot;";
            3'd1:    r = {"amp;", 8'h00};
            3'd2:    r = "apos;";
            3'd3:    r = {"lt;", 16'h0000};
            3'd4:    r = {"gt;", 16'h0000};
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] ent_char(input logic [2:0] i, input logic [2:0] pos);
        logic [39:0] n;
        logic [7:0]  r;
        n = ent_name(i);
        unique case (pos)
            3'd0:    r = n[39:32];
            3'd1:    r = n[31:24];
            3'd2:    r = n[23:16];
            3'd3:    r = n[15:8];
            3'd4:    r = n[7:0];
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] ent_len(input logic [2:0] i);
        logic [2:0] r;
        unique case (i)
            3'd0, 3'd2: r = 3'd5;
            3'd1:       r = 3'd4;
            default:    r = 3'd3;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] ent_val(input logic [2:0] i);
        logic [7:0] r;
        unique case (i)
            3'd0:    r = 8'h22;
            3'd1:    r = 8'h26;
            3'd2:    r = 8'h27;
            3'd3:    r = 8'h3C;
            default: r = 8'h3E;
        endcase
        return r;
    endfunction

endpackage

// ===== hw/rtl/tud_front.sv =====
// Front of the token unescape decoder: takes one byte per transfer, tracks the
// tokenizer state and turns each byte into at most one run descriptor. Depends on tud_pkg.
module tud_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [7:0]          char_in,
    input  logic                end_of_input,
    input  logic                accept,
    output logic                push,
    output tud_pkg::desc_t      push_desc
);

    typedef enum logic [1:0] {
        PH_SKIP,
        PH_BODY,
        PH_ESC,
        PH_ENT
    } phase_t;

    phase_t                             phase_reg, phase_next;
    logic                               quoted_reg, quoted_next;
    logic [tud_pkg::ENT_CNT_W-1:0]      cnt_reg, cnt_next;
    logic [tud_pkg::ENT_HOLD-1:0][7:0]  letters_reg, letters_next;

    // Body byte handling, shared by skip, body and failed-entity paths
    logic                   b_quoted;
    tud_pkg::kind_t         b_kind;
    logic [1:0]             b_cause;
    logic [7:0]             b_byte;
    phase_t                 b_phase;

    always_comb
    begin
        b_quoted = (phase_reg == PH_SKIP) ? 1'b0 : quoted_reg;
        b_kind   = tud_pkg::KIND_NONE;
        b_cause  = tud_pkg::CAUSE_TERM;
        b_byte   = 8'h00;
        b_phase  = PH_BODY;
        priority if (char_in == tud_pkg::CH_NUL)
        begin
            b_kind  = tud_pkg::KIND_END;
            b_cause = tud_pkg::CAUSE_NUL;
            b_phase = PH_SKIP;
        end
        else if (b_quoted && char_in == tud_pkg::CH_QUOTE)
        begin
            b_kind  = tud_pkg::KIND_END;
            b_cause = tud_pkg::CAUSE_QUOTE;
            b_phase = PH_SKIP;
        end
        else if (b_quoted && char_in == tud_pkg::CH_BSL)
        begin
            b_phase = PH_ESC;
        end
        else if (!b_quoted && tud_pkg::is_term(char_in))
        begin
            b_kind  = tud_pkg::KIND_END;
            b_cause = tud_pkg::CAUSE_TERM;
            b_byte  = char_in;
            b_phase = PH_SKIP;
        end
        else if (char_in == tud_pkg::CH_AMP)
        begin
            b_phase = PH_ENT;
        end
        else
        begin
            b_kind = tud_pkg::KIND_CHAR;
            b_byte = char_in;
        end
    end

    // Entity name match against held letters plus this byte
    logic       e_hit;
    logic       e_done;
    logic [7:0] e_val;

    always_comb
    begin
        logic ok;
        e_hit  = 1'b0;
        e_done = 1'b0;
        e_val  = 8'h00;
        for (int i = 0; i < tud_pkg::ENT_NUM; i++)
        begin
            ok = cnt_reg < tud_pkg::ent_len(3'(i));
            for (int j = 0; j < tud_pkg::ENT_HOLD; j++)
            begin
                if (3'(j) < cnt_reg && tud_pkg::ent_char(3'(i), 3'(j)) != letters_reg[j])
                    ok = 1'b0;
            end
            if (!e_hit && ok && tud_pkg::ent_char(3'(i), cnt_reg) == char_in)
            begin
                e_hit  = 1'b1;
                e_done = (cnt_reg + 3'd1) == tud_pkg::ent_len(3'(i));
                e_val  = tud_pkg::ent_val(3'(i));
            end
        end
    end

    // Next state and run descriptor
    always_comb
    begin
        phase_next   = phase_reg;
        quoted_next  = quoted_reg;
        cnt_next     = cnt_reg;
        letters_next = letters_reg;
        push_desc          = '0;
        push_desc.letters  = letters_reg;
        push_desc.quoted   = quoted_reg;
        push_desc.kind     = tud_pkg::KIND_NONE;
        if (end_of_input)
        begin
            push_desc.amp   = (phase_reg == PH_ENT);
            push_desc.nlet  = (phase_reg == PH_ENT) ? cnt_reg : '0;
            push_desc.kind  = tud_pkg::KIND_END;
            push_desc.cause = tud_pkg::CAUSE_EOI;
            phase_next      = PH_SKIP;
        end
        else
        begin
            unique case (phase_reg)
                PH_SKIP:
                begin
                    if (!tud_pkg::is_space(char_in))
                    begin
                        cnt_next = '0;
                        if (char_in == tud_pkg::CH_QUOTE)
                        begin
                            phase_next  = PH_BODY;
                            quoted_next = 1'b1;
                        end
                        else
                        begin
                            quoted_next        = 1'b0;
                            push_desc.quoted   = 1'b0;
                            push_desc.kind     = b_kind;
                            push_desc.cause    = b_cause;
                            push_desc.fin_byte = b_byte;
                            phase_next         = b_phase;
                        end
                    end
                end
                PH_BODY:
                begin
                    push_desc.kind     = b_kind;
                    push_desc.cause    = b_cause;
                    push_desc.fin_byte = b_byte;
                    phase_next         = b_phase;
                end
                PH_ESC:
                begin
                    push_desc.kind     = tud_pkg::KIND_CHAR;
                    push_desc.fin_byte = tud_pkg::esc_byte(char_in);
                    phase_next         = PH_BODY;
                end
                PH_ENT:
                begin
                    if (e_hit && e_done)
                    begin
                        push_desc.kind     = tud_pkg::KIND_CHAR;
                        push_desc.fin_byte = e_val;
                        phase_next         = PH_BODY;
                    end
                    else if (e_hit)
                    begin
                        letters_next[cnt_reg[1:0]] = char_in;
                        cnt_next                   = cnt_reg + 3'd1;
                    end
                    else
                    begin
                        // failed entity: flush '&' and letters, then rehandle byte;
                        // a breaking '&' opens a fresh entity
                        push_desc.amp      = 1'b1;
                        push_desc.nlet     = cnt_reg;
                        push_desc.kind     = b_kind;
                        push_desc.cause    = b_cause;
                        push_desc.fin_byte = b_byte;
                        phase_next         = b_phase;
                        cnt_next           = '0;
                    end
                end
                default:
                begin
                    phase_next = PH_SKIP;
                end
            endcase
        end
        // token end or entity start/finish clears the letter count
        if (phase_next != PH_ENT)
            cnt_next = '0;
        else if (phase_reg != PH_ENT)
            cnt_next = '0;
        if (phase_next == PH_SKIP)
            quoted_next = 1'b0;
    end

    assign push = accept && (push_desc.amp || push_desc.kind != tud_pkg::KIND_NONE);

    // Tokenizer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_SKIP;
            quoted_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            quoted_reg <= quoted_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Held entity letters, only read below the count
    always_ff @(posedge clk)
    begin
        if (accept)
            letters_reg <= letters_next;
    end

endmodule

// ===== hw/rtl/tud_queue.sv =====
// Short descriptor queue between front and back of the token unescape decoder.
// Depends on tud_pkg.
module tud_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  tud_pkg::desc_t      push_desc,
    output logic                full,
    input  logic                pop,
    output logic                not_empty,
    output tud_pkg::desc_t      head
);

    tud_pkg::desc_t                 entries_reg [tud_pkg::QUEUE_DEPTH];
    logic [tud_pkg::QPTR_W-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [tud_pkg::QPTR_W:0]       count_reg, count_next;

    assign full      = count_reg == (tud_pkg::QPTR_W+1)'(tud_pkg::QUEUE_DEPTH);
    assign not_empty = count_reg != '0;
    assign head      = entries_reg[rd_ptr_reg];

    // occupancy
    always_comb
    begin
        count_next = count_reg;
        unique case ({push, pop})
            2'b10:   count_next = count_reg + (tud_pkg::QPTR_W+1)'(1);
            2'b01:   count_next = count_reg - (tud_pkg::QPTR_W+1)'(1);
            default: count_next = count_reg;
        endcase
    end

    // pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + (tud_pkg::QPTR_W)'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + (tud_pkg::QPTR_W)'(1);
            count_reg <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            entries_reg[wr_ptr_reg] <= push_desc;
    end

endmodule

// ===== hw/rtl/tud_back.sv =====
// Back of the token unescape decoder: expands each run descriptor into result
// items into an output register, one per cycle unless out_stall holds it. Depends on tud_pkg.
module tud_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                not_empty,
    input  tud_pkg::desc_t      head,
    output logic                pop,
    input  logic                out_stall,
    output logic                out_valid,
    output tud_pkg::result_t    result
);

    tud_pkg::desc_t     cur_reg;
    logic               cur_valid_reg;
    logic [2:0]         idx_reg;
    logic               out_valid_reg;
    tud_pkg::result_t   result_reg, elem;

    logic       can_load, emit, is_last;
    logic [2:0] total;
    logic [1:0] lidx;

    assign can_load = !out_valid_reg || !out_stall;
    assign emit     = cur_valid_reg && can_load;
    assign total    = (cur_reg.amp ? cur_reg.nlet + 3'd1 : 3'd0) +
                      ((cur_reg.kind != tud_pkg::KIND_NONE) ? 3'd1 : 3'd0);
    assign is_last  = idx_reg == (total - 3'd1);
    assign pop      = not_empty && (!cur_valid_reg || (emit && is_last));
    assign lidx     = idx_reg[1:0] - 2'd1;

    // result at the current position of the run
    always_comb
    begin
        elem             = '0;
        elem.was_quoted  = cur_reg.quoted;
        elem.last_of_run = is_last;
        if (cur_reg.amp && idx_reg == 3'd0)
        begin
            elem.char_out   = tud_pkg::CH_AMP;
            elem.char_valid = 1'b1;
        end
        else if (cur_reg.amp && idx_reg <= cur_reg.nlet)
        begin
            elem.char_out   = cur_reg.letters[lidx];
            elem.char_valid = 1'b1;
        end
        else
        begin
            unique case (cur_reg.kind)
                tud_pkg::KIND_CHAR:
                begin
                    elem.char_out   = cur_reg.fin_byte;
                    elem.char_valid = 1'b1;
                end
                tud_pkg::KIND_END:
                begin
                    elem.token_end       = 1'b1;
                    elem.end_cause       = cur_reg.cause;
                    elem.terminator_byte = cur_reg.fin_byte;
                end
                default:
                begin
                    elem.char_valid = 1'b0;
                end
            endcase
        end
    end

    // run sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                cur_valid_reg <= 1'b1;
                idx_reg       <= '0;
            end
            else if (emit)
            begin
                cur_valid_reg <= !is_last;
                idx_reg       <= idx_reg + 3'd1;
            end
            if (can_load)
                out_valid_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            cur_reg <= head;
        if (emit)
            result_reg <= elem;
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

endmodule

// ===== hw/rtl/token_unescape_decoder_core.sv =====
// channel | direction | handshake              | payload
// input   | in        | in_valid / in_stall    | char_in, end_of_input
// output  | out       | out_valid / out_stall  | char_out .. last_of_run
//
// One input byte per cycle while in_stall is low; the back gives one result per
// cycle unless out_stall holds it, so a byte that flushes a failed entity
// gives up to six results. An input byte reaches the output through the
// four-entry descriptor queue, the current-run register and the output register.
// in_stall rises only while that queue is full; out_stall holds the output register.
// Reset (rst_n, asynchronous) returns to skipping whitespace with an empty queue.
// Depends on tud_pkg, tud_front, tud_queue and tud_back.
module token_unescape_decoder_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  char_in,
    input  logic        end_of_input,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  char_out,
    output logic        char_valid,
    output logic        token_end,
    output logic [1:0]  end_cause,
    output logic [7:0]  terminator_byte,
    output logic        was_quoted,
    output logic        last_of_run
);

    logic               full, accept, push, pop, not_empty;
    tud_pkg::desc_t     push_desc, head;
    tud_pkg::result_t   result;

    assign in_stall = full;
    assign accept   = in_valid && !full;

    tud_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_in      (char_in),
        .end_of_input (end_of_input),
        .accept       (accept),
        .push         (push),
        .push_desc    (push_desc)
    );

    tud_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .full      (full),
        .pop       (pop),
        .not_empty (not_empty),
        .head      (head)
    );

    tud_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .not_empty (not_empty),
        .head      (head),
        .pop       (pop),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .result    (result)
    );

    assign char_out        = result.char_out;
    assign char_valid      = result.char_valid;
    assign token_end       = result.token_end;
    assign end_cause       = result.end_cause;
    assign terminator_byte = result.terminator_byte;
    assign was_quoted      = result.was_quoted;
    assign last_of_run     = result.last_of_run;

endmodule

// ===== hw/rtl/tud_checker.sv =====
// Port-level checks of the token unescape decoder, bound to the top level.
// Depends on tud_pkg and on token_unescape_decoder_core only through its ports.
module tud_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [7:0]  char_out,
    input  logic        char_valid,
    input  logic        token_end,
    input  logic [1:0]  end_cause,
    input  logic [7:0]  terminator_byte,
    input  logic        last_of_run
);

    // a stalled result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(char_out) && $stable(token_end))
        else $error("output transfer changed while stalled");

    // every result carries exactly one of a byte or a token end
    a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (char_valid != token_end))
        else $error("result is neither a byte nor a token end, or both");

    // a token end closes the run of its input byte
    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && token_end |-> last_of_run)
        else $error("token end not last of run");

    // cause and terminator are clear on byte results, terminator only for a terminator end
    a_end_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (!token_end || end_cause != tud_pkg::CAUSE_TERM) |->
        terminator_byte == 8'h00 && (token_end || end_cause == tud_pkg::CAUSE_TERM))
        else $error("stray end cause or terminator byte");

endmodule

bind token_unescape_decoder_core tud_checker u_tud_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .char_out        (char_out),
    .char_valid      (char_valid),
    .token_end       (token_end),
    .end_cause       (end_cause),
    .terminator_byte (terminator_byte),
    .last_of_run     (last_of_run)
);

// ===== sim/token_unescape_decoder_core_tb.sv =====
// Self-checking testbench of token_unescape_decoder_core: directed and random byte streams,
// with an in-bench tokeniser model predicting every result transfer.
// Depends on tud_pkg and the RTL of the decoder core.
module token_unescape_decoder_core_tb;

    // Scanner phases of the prediction
    typedef enum logic [2:0] {
        SCAN_SKIP,
        SCAN_BODY,
        SCAN_ESC,
        SCAN_ENT
    } scan_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  char_in;
    logic        end_of_input;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  char_out;
    logic        char_valid;
    logic        token_end;
    logic [1:0]  end_cause;
    logic [7:0]  terminator_byte;
    logic        was_quoted;
    logic        last_of_run;

    // Prediction state
    scan_t              ph = SCAN_SKIP;
    logic               in_quotes = 1'b0;
    logic [7:0]         held [4];
    logic [2:0]         held_n = 3'd0;
    tud_pkg::result_t   step_results [$];
    tud_pkg::result_t   expected_results [$];

    int          mismatches = 0;
    int          token_bytes = 0;
    int          stall_left = 0;
    logic        idle_on = 1'b1;

    token_unescape_decoder_core DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .char_in         (char_in),
        .end_of_input    (end_of_input),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .char_out        (char_out),
        .char_valid      (char_valid),
        .token_end       (token_end),
        .end_cause       (end_cause),
        .terminator_byte (terminator_byte),
        .was_quoted      (was_quoted),
        .last_of_run     (last_of_run)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit, far beyond the slowest legal run
    initial
    begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

    // ---------------------------------------------------------------- prediction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    // Bytes closing an unquoted token; form feed is not among them
    function automatic logic ends_bare(input logic [7:0] c);
        case (c)
            " ", "\t", "\n", "\r", 8'h0B, ">", "\\", "=": return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic [7:0] unescape(input logic [7:0] c);
        case (c)
            "a":     return 8'h07;
            "b":     return 8'h08;
            "f":     return 8'h0C;
            "n":     return 8'h0A;
            "r":     return 8'h0D;
            "t":     return 8'h09;
            "v":     return 8'h0B;
            default: return c;
        endcase
    endfunction

    function automatic string ent_name_of(input int k);
        case (k)
            0:       return "quot;";
            1:       return "amp;";
            2:       return "apos;";
            3:       return "lt;";
            default: return "gt;";
        endcase
    endfunction

    function automatic void add_result(input logic [7:0] ch, input logic v, input logic te,
                                       input logic [1:0] cause, input logic [7:0] term);
        tud_pkg::result_t r;
        r.char_out        = ch;
        r.char_valid      = v;
        r.token_end       = te;
        r.end_cause       = cause;
        r.terminator_byte = term;
        r.was_quoted      = in_quotes;
        r.last_of_run     = 1'b0;
        step_results.insert(step_results.size(), r);
    endfunction

    function automatic void close_token(input logic [1:0] cause, input logic [7:0] term);
        add_result(8'h00, 1'b0, 1'b1, cause, term);
        ph        = SCAN_SKIP;
        in_quotes = 1'b0;
        held_n    = 3'd0;
    endfunction

    // Failed entity: '&' and the held letters come out as plain bytes
    function automatic void flush_held();
        add_result(tud_pkg::CH_AMP, 1'b1, 1'b0, tud_pkg::CAUSE_TERM, 8'h00);
        for (int i = 0; i < int'(held_n); i++)
            add_result(held[i], 1'b1, 1'b0, tud_pkg::CAUSE_TERM, 8'h00);
        held_n = 3'd0;
        ph     = SCAN_BODY;
    endfunction

    function automatic void body_byte(input logic [7:0] c);
        if (c == tud_pkg::CH_NUL)
            close_token(tud_pkg::CAUSE_NUL, 8'h00);
        else if (in_quotes && c == tud_pkg::CH_QUOTE)
            close_token(tud_pkg::CAUSE_QUOTE, 8'h00);
        else if (in_quotes && c == tud_pkg::CH_BSL)
            ph = SCAN_ESC;
        else if (!in_quotes && ends_bare(c))
            close_token(tud_pkg::CAUSE_TERM, c);
        else if (c == tud_pkg::CH_AMP)
        begin
            ph     = SCAN_ENT;
            held_n = 3'd0;
        end
        else
            add_result(c, 1'b1, 1'b0, tud_pkg::CAUSE_TERM, 8'h00);
    endfunction

    function automatic void entity_byte(input logic [7:0] c);
        string nm;
        string vals;
        logic  ok;
        logic  done;
        int    n;
        vals = "\"&'<>";
        n    = int'(held_n);
        done = 1'b0;
        for (int k = 0; k < 5; k++)
        begin
            if (!done)
            begin
                nm = ent_name_of(k);
                ok = (n < nm.len());
                for (int j = 0; j < n; j++)
                    if (ok && nm[j] != held[j]) ok = 1'b0;
                if (ok && nm[n] == c)
                begin
                    done = 1'b1;
                    if (n + 1 == nm.len())
                    begin
                        add_result(vals[k], 1'b1, 1'b0, tud_pkg::CAUSE_TERM, 8'h00);
                        held_n = 3'd0;
                        ph     = SCAN_BODY;
                    end
                    else
                    begin
                        held[n] = c;
                        held_n  = 3'(n + 1);
                    end
                end
            end
        end
        // Breaking byte is handled again as a body byte
        if (!done)
        begin
            flush_held();
            body_byte(c);
        end
    endfunction

    // Works out the results of one accepted input transfer
    function automatic void decode_transfer(input logic [7:0] c, input logic eoi);
        tud_pkg::result_t r;
        step_results.delete();
        if (eoi)
        begin
            if (ph == SCAN_ENT) flush_held();
            close_token(tud_pkg::CAUSE_EOI, 8'h00);
        end
        else
        begin
            case (ph)
                SCAN_SKIP:
                    if (!is_blank(c))
                    begin
                        ph     = SCAN_BODY;
                        held_n = 3'd0;
                        if (c == tud_pkg::CH_QUOTE)
                            in_quotes = 1'b1;
                        else
                        begin
                            in_quotes = 1'b0;
                            body_byte(c);
                        end
                    end
                SCAN_BODY:
                    body_byte(c);
                SCAN_ESC:
                begin
                    add_result(unescape(c), 1'b1, 1'b0, tud_pkg::CAUSE_TERM, 8'h00);
                    ph = SCAN_BODY;
                end
                default:
                    entity_byte(c);
            endcase
        end
        for (int i = 0; i < step_results.size(); i++)
        begin
            r             = step_results[i];
            r.last_of_run = (i == step_results.size() - 1);
            expected_results.insert(expected_results.size(), r);
        end
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic compare_field(input string label, input logic [7:0] want_v,
                                 input logic [7:0] got_v);
        if (got_v !== want_v)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, label, want_v, got_v);
        end
    endtask

    // Predict on each input transfer, compare each output transfer
    always @(posedge clk)
    begin : result_check
        tud_pkg::result_t want;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                decode_transfer(char_in, end_of_input);
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result, expected none, actual char_out %0h",
                             $time, char_out);
                end
                else
                begin
                    want = expected_results.pop_front();
                    compare_field("char_out", want.char_out, char_out);
                    compare_field("char_valid", 8'(want.char_valid), 8'(char_valid));
                    compare_field("token_end", 8'(want.token_end), 8'(token_end));
                    compare_field("end_cause", 8'(want.end_cause), 8'(end_cause));
                    compare_field("terminator_byte", want.terminator_byte, terminator_byte);
                    compare_field("was_quoted", 8'(want.was_quoted), 8'(was_quoted));
                    compare_field("last_of_run", 8'(want.last_of_run), 8'(last_of_run));
                end
            end
        end
    end

    // Random output stall bursts, started only while idle_on is set
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end
        else if (idle_on && $urandom_range(0, 4) == 0)
        begin
            stall_left <= $urandom_range(0, 3);
            out_stall  <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // ---------------------------------------------------------------- stimulus

    // One input transfer, with an occasional idle burst ahead of it
    task automatic send_byte(input logic [7:0] c, input logic eoi);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        char_in      <= c;
        end_of_input <= eoi;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic send_eoi();
        logic [7:0] junk;
        junk = 8'($urandom_range(0, 255));
        send_byte(junk, 1'b1);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], 1'b0);
    endtask

    // Whitespace skip, entity in a bare token, terminator, form feed inside a token, NUL
    task automatic test_bare_tokens();
        send_text(" &gt;=");
        send_byte(8'hFF, 1'b0);
        send_byte(8'h0C, 1'b0);
        send_byte(tud_pkg::CH_NUL, 1'b0);
    endtask

    // Escapes incl. escaped NUL and quote; failed "&quot" broken by the closing quote
    task automatic test_quoted_escapes();
        send_text("\"\\n\\");
        send_byte(tud_pkg::CH_NUL, 1'b0);
        send_text("\\\"&quot\"");
    endtask

    // Dangling backslash, empty token while skipping, partial entity at the end
    task automatic test_end_of_input();
        send_text("\"\\");
        send_eoi();
        send_eoi();
        send_text("&l");
        send_eoi();
    endtask

    // One mostly well-formed token with random content
    task automatic send_random_token();
        string      term_set;
        string      esc_set;
        string      nm;
        logic [7:0] b;
        logic       quoted;
        int         mode;
        int         cut;
        term_set = " \t\n\r\013>\\=";
        esc_set  = "abfnrtv\"\\&q";
        repeat ($urandom_range(0, 2))
        begin
            b = 8'($urandom_range(9, 13));
            if ($urandom_range(0, 1)) b = 8'h20;
            send_byte(b, 1'b0);
        end
        mode = $urandom_range(0, 9);
        if (mode == 9)
        begin
            // noise
            repeat (4)
            begin
                b = 8'($urandom_range(0, 255));
                send_byte(b, $urandom_range(0, 15) == 0);
                token_bytes++;
            end
        end
        else
        begin
            quoted = (mode < 5);
            if (quoted)
            begin
                send_byte(tud_pkg::CH_QUOTE, 1'b0);
                token_bytes++;
            end
            repeat ($urandom_range(0, 5))
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2:
                    begin
                        b = 8'($urandom_range(8'h61, 8'h7A));
                        send_byte(b, 1'b0);
                        token_bytes++;
                    end
                    3:
                    begin
                        b = 8'($urandom_range(8'h21, 8'h7E));
                        send_byte(b, 1'b0);
                        token_bytes++;
                    end
                    4, 5:
                    begin
                        // whole entity or a prefix that the next byte may break
                        nm  = ent_name_of($urandom_range(0, 4));
                        cut = nm.len();
                        if ($urandom_range(0, 3) == 0) cut = $urandom_range(0, nm.len() - 1);
                        send_byte(tud_pkg::CH_AMP, 1'b0);
                        token_bytes++;
                        for (int i = 0; i < cut; i++)
                        begin
                            send_byte(nm[i], 1'b0);
                            token_bytes++;
                        end
                    end
                    6, 7:
                    begin
                        if (quoted)
                        begin
                            send_byte(tud_pkg::CH_BSL, 1'b0);
                            token_bytes++;
                            b = esc_set[$urandom_range(0, esc_set.len() - 1)];
                            if ($urandom_range(0, 4) == 0) b = 8'($urandom_range(0, 255));
                        end
                        else
                            b = 8'($urandom_range(8'h61, 8'h7A));
                        send_byte(b, 1'b0);
                        token_bytes++;
                    end
                    8:
                    begin
                        b = 8'($urandom_range(0, 255));
                        send_byte(b, 1'b0);
                        token_bytes++;
                    end
                    default:
                    begin
                        // whitespace is plain inside quotes; form feed is plain in both
                        b = 8'h0C;
                        if (quoted) b = term_set[$urandom_range(0, 4)];
                        send_byte(b, 1'b0);
                        token_bytes++;
                    end
                endcase
            end
            case ($urandom_range(0, 9))
                0: send_eoi();
                1: send_byte(tud_pkg::CH_NUL, 1'b0);
                default:
                begin
                    b = term_set[$urandom_range(0, 7)];
                    if (quoted) b = tud_pkg::CH_QUOTE;
                    send_byte(b, 1'b0);
                end
            endcase
            token_bytes++;
        end
    endtask

    task automatic test_random_stream();
        while (token_bytes < 70) send_random_token();
    endtask

    // Back-to-back transfers on both sides
    task automatic test_random_no_idle();
        idle_on = 1'b0;
        while (token_bytes < 110) send_random_token();
        send_eoi();
    endtask

    initial
    begin
        in_valid     <= 1'b0;
        char_in      <= 8'h00;
        end_of_input <= 1'b0;
        rst_n        <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_bare_tokens();
        test_quoted_escapes();
        test_end_of_input();
        test_random_stream();
        test_random_no_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        // drain, then allow for the pipeline latency
        while (expected_results.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
